/* rtl/smf_pkg.sv */
// Shared types, register map and helpers of the substring match finder.
package smf_pkg;

    localparam int MAX_PATTERN_DEF   = 32;
    localparam int POSITION_BITS_DEF = 16;

    localparam int PAT_WORDS     = 4;
    localparam int PAT_WORD_BITS = 64;
    localparam int PAT_BITS      = PAT_WORDS * PAT_WORD_BITS;
    localparam int LEN_BITS      = 6;
    localparam int DATA_BITS     = 64;
    localparam int ADDR_BITS     = 6;
    localparam int REG_IDX_BITS  = 3;

    localparam logic [REG_IDX_BITS-1:0] REG_PATTERN_0  = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_PATTERN_1  = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_PATTERN_2  = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_PATTERN_3  = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_LENGTH     = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_IGNORECASE = 3'd5;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       line_end;
    } t_in_item;

    typedef struct packed {
        logic [15:0] match_start;
        logic        first_in_line;
    } t_out_item;

    typedef struct packed {
        logic [PAT_BITS-1:0] pattern;
        logic [LEN_BITS-1:0] length;
        logic                case_fold;
    } t_cfg;

    function automatic logic [7:0] fold(input logic [7:0] c, input logic en);
        logic [7:0] r;
        r = c;
        if (en && c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

/* rtl/smf_cfg.sv */
// APB register file holding pattern, pattern length and case folding.
module smf_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [smf_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [smf_pkg::DATA_BITS-1:0]  pwdata,
    output logic [smf_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready,
    output smf_pkg::t_cfg                  o_cfg
);
    import smf_pkg::*;

    logic [PAT_BITS-1:0]     r_pattern;
    logic [LEN_BITS-1:0]     r_length;
    logic                    r_case_fold;
    logic [REG_IDX_BITS-1:0] idx;
    logic                    wr;

    assign pready = 1'b1;
    assign idx    = paddr[ADDR_BITS-1:ADDR_BITS-REG_IDX_BITS];
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern   <= '0;
            r_length    <= LEN_BITS'(1);
            r_case_fold <= 1'b0;
        end else if (wr) begin
            unique case (idx)
                REG_PATTERN_0:  r_pattern[0*PAT_WORD_BITS +: PAT_WORD_BITS] <= pwdata;
                REG_PATTERN_1:  r_pattern[1*PAT_WORD_BITS +: PAT_WORD_BITS] <= pwdata;
                REG_PATTERN_2:  r_pattern[2*PAT_WORD_BITS +: PAT_WORD_BITS] <= pwdata;
                REG_PATTERN_3:  r_pattern[3*PAT_WORD_BITS +: PAT_WORD_BITS] <= pwdata;
                REG_LENGTH:     r_length    <= pwdata[LEN_BITS-1:0];
                REG_IGNORECASE: r_case_fold <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_PATTERN_0:  prdata = r_pattern[0*PAT_WORD_BITS +: PAT_WORD_BITS];
            REG_PATTERN_1:  prdata = r_pattern[1*PAT_WORD_BITS +: PAT_WORD_BITS];
            REG_PATTERN_2:  prdata = r_pattern[2*PAT_WORD_BITS +: PAT_WORD_BITS];
            REG_PATTERN_3:  prdata = r_pattern[3*PAT_WORD_BITS +: PAT_WORD_BITS];
            REG_LENGTH:     prdata = DATA_BITS'(r_length);
            REG_IGNORECASE: prdata = DATA_BITS'(r_case_fold);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.pattern   = r_pattern;
    assign o_cfg.length    = r_length;
    assign o_cfg.case_fold = r_case_fold;

endmodule

/* rtl/smf_cell.sv */
// One window cell: holds one text byte of the line and compares the byte entering it.
module smf_cell (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  logic       i_clr,
    input  logic [7:0] i_byte,
    input  logic       i_valid,
    input  logic [7:0] i_pat,
    input  logic       i_fold,
    output logic [7:0] o_byte,
    output logic       o_valid,
    output logic       o_eq
);
    import smf_pkg::*;

    logic [7:0] r_byte;
    logic       r_valid;

    assign o_eq    = (fold(i_byte, i_fold) == fold(i_pat, i_fold));
    assign o_byte  = r_byte;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte  <= 8'h00;
            r_valid <= 1'b0;
        end else if (i_adv) begin
            if (i_clr) begin
                r_byte  <= 8'h00;
                r_valid <= 1'b0;
            end else begin
                r_byte  <= i_byte;
                r_valid <= i_valid;
            end
        end
    end

endmodule

/* rtl/substring_match_finder_core.sv */
// Top level of the substring match finder: register file, cell chain, output stage.
// Each accepted text byte enters a chain of MAX_PATTERN cells that hold the line's most
// recent bytes, each cell handing its byte and valid flag to its neighbor. In the same
// cycle every window position is compared against the pattern byte that lines up with it
// for the current pattern length, so one byte is taken per cycle except while a result is
// held and the output side stalls; a match is registered in the cycle after its last byte.
// Results sit in a single output register, which is refilled in the cycle it is drained.
// match_start saturates at the position counter's maximum.
module substring_match_finder_core #(
    parameter int MAX_PATTERN   = smf_pkg::MAX_PATTERN_DEF,
    parameter int POSITION_BITS = smf_pkg::POSITION_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  smf_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output smf_pkg::t_out_item             o_out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [smf_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [smf_pkg::DATA_BITS-1:0]  pwdata,
    output logic [smf_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready
);
    import smf_pkg::*;

    localparam logic [POSITION_BITS-1:0] PosMax = '1;

    t_cfg                     cfg;
    logic                     accept;
    logic [7:0]               win_byte [MAX_PATTERN];
    logic [MAX_PATTERN-1:0]   win_valid;
    logic [MAX_PATTERN-1:0]   in_valid;
    logic [MAX_PATTERN-1:0]   eqs;
    logic [8*MAX_PATTERN-1:0] pat_rev;
    logic [8*MAX_PATTERN-1:0] pat_aligned;
    logic [LEN_BITS-1:0]      align_sh;
    logic [LEN_BITS-1:0]      eff_len;
    logic                     all_eq;
    logic                     enough;
    logic                     hit;
    logic [POSITION_BITS-1:0] start;
    logic [POSITION_BITS-1:0] r_pos;
    logic                     r_line_matched;
    logic                     r_out_valid;
    t_out_item                r_out;

    smf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    assign eff_len = (cfg.length > LEN_BITS'(MAX_PATTERN)) ? LEN_BITS'(MAX_PATTERN)
                                                          : cfg.length;

    // window position j meets pattern byte eff_len-1-j
    assign align_sh    = LEN_BITS'(MAX_PATTERN) - eff_len;
    assign pat_aligned = pat_rev >> {align_sh, 3'b000};

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        logic [7:0] byte_in;
        logic       valid_in;
        if (k == 0) begin : g_first
            assign byte_in  = i_in_data.text_byte;
            assign valid_in = 1'b1;
        end else begin : g_rest
            assign byte_in  = win_byte[k-1];
            assign valid_in = win_valid[k-1];
        end
        assign in_valid[k]         = valid_in;
        assign pat_rev[8*k +: 8]   = cfg.pattern[8*(MAX_PATTERN-1-k) +: 8];
        smf_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (accept),
            .i_clr   (i_in_data.line_end),
            .i_byte  (byte_in),
            .i_valid (valid_in),
            .i_pat   (pat_aligned[8*k +: 8]),
            .i_fold  (cfg.case_fold),
            .o_byte  (win_byte[k]),
            .o_valid (win_valid[k]),
            .o_eq    (eqs[k])
        );
    end

    always_comb begin
        all_eq = 1'b1;
        enough = 1'b0;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (LEN_BITS'(k) < eff_len && !eqs[k]) begin
                all_eq = 1'b0;
            end
            if (eff_len == LEN_BITS'(k + 1) && in_valid[k]) begin
                enough = 1'b1;
            end
        end
        hit = all_eq && enough;
    end

    assign start = (r_pos == PosMax) ? PosMax
                 : r_pos - (POSITION_BITS'(eff_len) - POSITION_BITS'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos          <= '0;
            r_line_matched <= 1'b0;
            r_out_valid    <= 1'b0;
        end else if (accept) begin
            r_out_valid <= hit;
            if (i_in_data.line_end) begin
                r_pos          <= '0;
                r_line_matched <= 1'b0;
            end else begin
                if (r_pos != PosMax) begin
                    r_pos <= r_pos + POSITION_BITS'(1);
                end
                if (hit) begin
                    r_line_matched <= 1'b1;
                end
            end
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && hit) begin
            r_out.match_start   <= 16'(start);
            r_out.first_in_line <= !r_line_matched;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* tb/substring_match_finder_core_tb.sv */
// Self-checking testbench for substring_match_finder_core: directed and random text streams.
module substring_match_finder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import smf_pkg::*;

    localparam int WIN_DEPTH    = 32;
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASE_ITEMS  = 300;
    localparam int CONFIG_ITEMS = 60;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_data;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_BITS-1:0]  paddr = '0;
    logic [DATA_BITS-1:0]  pwdata = '0;
    logic [DATA_BITS-1:0]  prdata;
    logic                  pready;

    // register mirror
    logic [PAT_BITS-1:0]   cfg_pattern = '0;
    logic [LEN_BITS-1:0]   cfg_length = 6'd1;
    logic                  cfg_fold = 1'b0;

    // predictor state
    logic [7:0]            win_bytes [WIN_DEPTH];
    int                    win_count = 0;
    logic [15:0]           line_pos = '0;
    logic                  line_hit = 1'b0;

    t_out_item             match_q [$];
    t_out_item             want;
    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;
    int                    errors = 0;
    int                    bytes_sent = 0;
    int                    matches_seen = 0;
    int                    configs_loaded = 0;
    int                    cycle_count = 0;

    substring_match_finder_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** substring_match_finder_core: FAILED **");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            matches_seen++;
            if (match_q.size() == 0) begin
                $error("unexpected match: match_start=%0d first_in_line=%0d",
                       o_out_data.match_start, o_out_data.first_in_line);
                errors++;
            end else begin
                want = match_q.pop_front();
                if (o_out_data.match_start !== want.match_start) begin
                    $error("match_start: expected %0d, actual %0d",
                           want.match_start, o_out_data.match_start);
                    errors++;
                end
                if (o_out_data.first_in_line !== want.first_in_line) begin
                    $error("first_in_line: expected %0d, actual %0d",
                           want.first_in_line, o_out_data.first_in_line);
                    errors++;
                end
            end
        end
    end

    function automatic int effective_length();
        return (cfg_length > WIN_DEPTH) ? WIN_DEPTH : int'(cfg_length);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if (cfg_fold && c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'h20;
        end
        return c;
    endfunction

    function automatic void clear_line();
        for (int k = 0; k < WIN_DEPTH; k++) begin
            win_bytes[k] = 8'h00;
        end
        win_count = 0;
        line_pos  = '0;
        line_hit  = 1'b0;
    endfunction

    function automatic bit predict_match(input t_in_item it, output t_out_item res);
        int eff;
        bit hit;
        eff = effective_length();
        for (int k = WIN_DEPTH - 1; k > 0; k--) begin
            win_bytes[k] = win_bytes[k-1];
        end
        win_bytes[0] = it.text_byte;
        if (win_count < WIN_DEPTH) begin
            win_count++;
        end
        hit = 1'b0;
        res = '0;
        if (eff > 0 && win_count >= eff) begin
            hit = 1'b1;
            for (int k = 0; k < eff; k++) begin
                if (to_lower(win_bytes[eff-1-k]) != to_lower(cfg_pattern[8*k +: 8])) begin
                    hit = 1'b0;
                end
            end
        end
        if (hit) begin
            res.match_start   = (line_pos == 16'hFFFF) ? 16'hFFFF : line_pos - 16'(eff - 1);
            res.first_in_line = !line_hit;
            line_hit = 1'b1;
        end
        if (line_pos != 16'hFFFF) begin
            line_pos++;
        end
        if (it.line_end) begin
            clear_line();
        end
        return hit;
    endfunction

    function automatic logic [PAT_BITS-1:0] pattern_from_string(input string s);
        logic [PAT_BITS-1:0] p;
        p = '0;
        for (int i = 0; i < s.len() && i < WIN_DEPTH; i++) begin
            p[8*i +: 8] = s[i];
        end
        return p;
    endfunction

    function automatic logic [7:0] letterish_byte();
        logic [7:0] c;
        if ($urandom_range(1)) begin
            c = 8'($urandom_range(255));
        end else begin
            c = 8'h61 + 8'($urandom_range(2));
            if ($urandom_range(1)) begin
                c = c - 8'h20;
            end
        end
        return c;
    endfunction

    function automatic logic [7:0] noise_byte();
        int eff;
        eff = effective_length();
        case ($urandom_range(2))
            0: return 8'($urandom_range(255));
            1: return cfg_pattern[8*$urandom_range(0, (eff > 0) ? eff - 1 : 0) +: 8];
            default: return letterish_byte();
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic le);
        t_in_item  it;
        t_out_item res;
        it.text_byte = b;
        it.line_end  = le;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        if (predict_match(it, res)) begin
            match_q.push_back(res);
        end
        bytes_sent++;
    endtask

    task automatic send_text(input string s, input bit end_line);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], end_line && (i == s.len() - 1));
        end
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (match_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_PATTERN_0:  cfg_pattern[63:0]    = val;
            REG_PATTERN_1:  cfg_pattern[127:64]  = val;
            REG_PATTERN_2:  cfg_pattern[191:128] = val;
            REG_PATTERN_3:  cfg_pattern[255:192] = val;
            REG_LENGTH:     cfg_length = val[LEN_BITS-1:0];
            REG_IGNORECASE: cfg_fold = val[0];
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [PAT_BITS-1:0] pat, input logic [LEN_BITS-1:0] len,
                               input logic fold);
        wait_drain();
        write_reg(REG_PATTERN_0, pat[63:0]);
        write_reg(REG_PATTERN_1, pat[127:64]);
        write_reg(REG_PATTERN_2, pat[191:128]);
        write_reg(REG_PATTERN_3, pat[255:192]);
        write_reg(REG_LENGTH, 64'(len));
        write_reg(REG_IGNORECASE, 64'(fold));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        configs_loaded++;
    endtask

    task automatic send_random_line(input int len_line, input bit well_formed, input bit terminate);
        logic [7:0] line_buf [64];
        logic [7:0] c;
        int eff;
        int at;
        eff = effective_length();
        for (int i = 0; i < len_line; i++) begin
            line_buf[i] = noise_byte();
        end
        if (well_formed && eff > 0) begin
            repeat ($urandom_range(1, 2)) begin
                at = (len_line >= eff) ? $urandom_range(0, len_line - eff) : 0;
                for (int k = 0; k < eff && at + k < len_line; k++) begin
                    c = cfg_pattern[8*k +: 8];
                    if (cfg_fold && $urandom_range(1) &&
                        ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A))) begin
                        c = c ^ 8'h20;
                    end
                    line_buf[at+k] = c;
                end
            end
        end
        for (int i = 0; i < len_line; i++) begin
            send_byte(line_buf[i], terminate && (i == len_line - 1));
        end
    endtask

    // defaults after reset: one-byte pattern of zero
    task automatic test_reset_state();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_overlap_and_case();
        load_config(pattern_from_string("aba"), 6'd3, 1'b1);
        send_text("AbAbA", 1'b1);
        load_config(pattern_from_string("aba"), 6'd3, 1'b0);
        send_text("ABAaba", 1'b1);
    endtask

    task automatic test_line_end_clears();
        load_config(pattern_from_string("ab"), 6'd2, 1'b0);
        send_text("xa", 1'b1);
        send_text("b", 1'b1);
        send_text("ab", 1'b1);
    endtask

    task automatic test_zero_length();
        load_config('0, 6'd0, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_random_traffic();
        int idle_mix [4] = '{0, 54, 0, 34};
        int stall_mix [4] = '{0, 0, 54, 34};
        int phase_start;
        int cfg_start;
        int cfg_idx;
        int r;
        int eff;
        logic [PAT_BITS-1:0] pat;
        logic [LEN_BITS-1:0] len;
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = idle_mix[ph];
            recv_stall_pct = stall_mix[ph];
            phase_start = bytes_sent;
            cfg_idx = 0;
            while (bytes_sent - phase_start < PHASE_ITEMS) begin
                r = $urandom_range(9);
                case (cfg_idx)
                    0: len = 6'd32;
                    1: len = 6'd1;
                    default: begin
                        case (r)
                            0: len = 6'd0;
                            1: len = 6'($urandom_range(33, 63));
                            2, 3: len = 6'($urandom_range(2, 32));
                            default: len = 6'($urandom_range(1, 6));
                        endcase
                    end
                endcase
                for (int k = 0; k < WIN_DEPTH; k++) begin
                    pat[8*k +: 8] = letterish_byte();
                end
                r = $urandom_range(9);
                if (r == 0) begin
                    pat = '0;
                end else if (r == 1) begin
                    pat = '1;
                end
                load_config(pat, len, 1'($urandom_range(1)));
                eff = effective_length();
                cfg_start = bytes_sent;
                while (bytes_sent - cfg_start < CONFIG_ITEMS) begin
                    send_random_line($urandom_range(1, eff + 12), $urandom_range(9) < 7,
                                     $urandom_range(9) != 0);
                end
                cfg_idx++;
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        clear_line();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_overlap_and_case();
        test_line_end_clears();
        test_zero_length();
        test_random_traffic();
        wait_drain();
        $display("Sent %0d text bytes under %0d register settings, checked %0d matches,",
                 bytes_sent, configs_loaded, matches_seen);
        $display("with idle and stall mixes on both sides and lines left open across settings.");
        if (errors == 0) begin
            $display("** substring_match_finder_core: PASSED **");
        end else begin
            $display("** substring_match_finder_core: FAILED **");
        end
        $finish;
    end

endmodule

/* substring_match_finder_core.f */
rtl/smf_pkg.sv
rtl/smf_cfg.sv
rtl/smf_cell.sv
rtl/substring_match_finder_core.sv
tb/substring_match_finder_core_tb.sv
